// ===== src/gbn_pkg.sv =====
// shared types, codes and constants of the go-back-n sender
`default_nettype none

package gbn_pkg;

    // fixed field widths
    localparam int SEQ_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int WIN_BITS     = 4;

    // most packets ever outstanding, and the width of a count up to it
    localparam int MAX_OUT = 8;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    // default store depth and window after reset
    localparam int BUFFER_DEPTH_DEF = 8;
    localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(4);

    // command codes
    localparam logic [1:0] CMD_SEND    = 2'd0;
    localparam logic [1:0] CMD_ACK     = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    // timer action codes
    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;
    localparam logic [1:0] TMR_RESTART = 2'd3;

    // input item
    typedef struct packed {
        logic [1:0]              command;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [SEQ_BITS-1:0]     ack_num;
        logic                    ack_ok;
    } t_in_item;

    // result item
    typedef struct packed {
        logic                    accepted;
        logic                    pkt_valid;
        logic [SEQ_BITS-1:0]     pkt_seq;
        logic [PAYLOAD_BITS-1:0] pkt_payload;
        logic [1:0]              timer_action;
        logic                    window_full;
        logic                    last;
    } t_out_item;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_RETX
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic retx_step;
    } t_dp_ctrl;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic starts_burst;
        logic burst_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/gbn_ctrl.sv =====
// controller state machine of the go-back-n sender
`default_nettype none

module gbn_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gbn_pkg::t_dp_status i_status,
    output gbn_pkg::t_dp_ctrl       o_ctrl
);

    gbn_pkg::t_state r_state;
    gbn_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbn_pkg::ST_IDLE: begin
                if (i_in_valid && i_status.out_free && i_status.starts_burst) begin
                    n_state = gbn_pkg::ST_RETX;
                end
            end
            gbn_pkg::ST_RETX: begin
                if (i_status.out_free && i_status.burst_last) begin
                    n_state = gbn_pkg::ST_IDLE;
                end
            end
            default: n_state = gbn_pkg::ST_IDLE;
        endcase
    end

    // outputs; no item is taken while reset is held
    always_comb begin
        o_in_stall       = 1'b1;
        o_ctrl.accept    = 1'b0;
        o_ctrl.retx_step = 1'b0;
        unique case (r_state)
            gbn_pkg::ST_IDLE: begin
                o_in_stall    = !i_status.out_free || !i_rst_n;
                o_ctrl.accept = i_in_valid && i_status.out_free && i_rst_n;
            end
            gbn_pkg::ST_RETX: begin
                o_ctrl.retx_step = i_status.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/gbn_dp.sv =====
// window registers, packet store and result register of the go-back-n sender
`default_nettype none

module gbn_dp #(
    parameter int BUFFER_DEPTH = gbn_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [gbn_pkg::WIN_BITS-1:0] i_cfg_wdata,
    input  wire gbn_pkg::t_in_item            i_in,
    input  wire gbn_pkg::t_dp_ctrl            i_ctrl,
    output gbn_pkg::t_dp_status               o_status,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output gbn_pkg::t_out_item                o_out
);

    localparam int SLOT_W = $clog2(BUFFER_DEPTH);
    localparam int CAP    = (BUFFER_DEPTH < gbn_pkg::MAX_OUT) ? BUFFER_DEPTH
                                                              : gbn_pkg::MAX_OUT;
    localparam int SB     = gbn_pkg::SEQ_BITS;
    localparam int CW     = gbn_pkg::CNT_W;

    // ring index modulo depth; the sum always stays below twice the depth
    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W:0] sum);
        logic [SLOT_W:0] red;
        red = (sum >= (SLOT_W+1)'(BUFFER_DEPTH)) ? sum - (SLOT_W+1)'(BUFFER_DEPTH) : sum;
        return red[SLOT_W-1:0];
    endfunction

    logic [gbn_pkg::WIN_BITS-1:0]     r_win_size;
    logic [SB-1:0]                    r_base;
    logic [SB-1:0]                    n_base;
    logic [SB-1:0]                    r_next;
    logic [SB-1:0]                    n_next;
    logic                             r_waiting;
    logic                             n_waiting;
    logic [SLOT_W-1:0]                r_base_slot;
    logic [SLOT_W-1:0]                n_base_slot;
    logic [CW-1:0]                    r_idx;
    logic [CW-1:0]                    n_idx;
    logic                             r_out_valid;
    gbn_pkg::t_out_item               r_out;
    gbn_pkg::t_out_item               n_res;
    logic                             load;

    logic [gbn_pkg::PAYLOAD_BITS-1:0] r_store [BUFFER_DEPTH];
    logic [gbn_pkg::PAYLOAD_BITS-1:0] r_rd_data;
    logic                             wr_en;
    logic [SLOT_W-1:0]                wr_addr;
    logic                             rd_en;
    logic [SLOT_W-1:0]                rd_addr;

    logic [CW-1:0]                    win;
    logic [SB-1:0]                    win_ext;
    logic [SB-1:0]                    outs;
    logic [CW-1:0]                    outs_c;
    logic [SB-1:0]                    ack_gap;
    logic [CW-1:0]                    adv;
    logic [SB-1:0]                    ack_next;
    logic [SB-1:0]                    outs_after_ack;
    logic [CW-1:0]                    idx_inc;
    logic                             send_ok;
    logic                             ack_good;

    // effective window, saturated to one .. min(depth, eight)
    always_comb begin
        win = CW'(r_win_size);
        if (r_win_size == '0) begin
            win = CW'(1);
        end else if (r_win_size > gbn_pkg::WIN_BITS'(CAP)) begin
            win = CW'(CAP);
        end
    end

    // window arithmetic; outstanding never exceeds eight
    assign win_ext        = SB'(win);
    assign outs           = r_next - r_base;
    assign outs_c         = outs[CW-1:0];
    assign ack_gap        = i_in.ack_num - r_base;
    assign adv            = ack_gap[CW-1:0] + CW'(1);
    assign ack_next       = i_in.ack_num + SB'(1);
    assign outs_after_ack = r_next - ack_next;
    assign idx_inc        = r_idx + CW'(1);
    assign send_ok        = !r_waiting && (outs < win_ext);
    assign ack_good       = i_in.ack_ok && (ack_gap < outs);

    // status to the controller
    assign o_status.out_free     = !r_out_valid || !i_out_stall;
    assign o_status.starts_burst = (i_in.command == gbn_pkg::CMD_TIMEOUT) && (outs != '0);
    assign o_status.burst_last   = (idx_inc == outs_c);

    // command execution and burst steps
    always_comb begin
        n_base            = r_base;
        n_next            = r_next;
        n_waiting         = r_waiting;
        n_base_slot       = r_base_slot;
        n_idx             = r_idx;
        wr_en             = 1'b0;
        wr_addr           = wrap_slot((SLOT_W+1)'(r_base_slot) + (SLOT_W+1)'(outs_c));
        rd_en             = 1'b0;
        rd_addr           = r_base_slot;
        load              = 1'b0;
        n_res             = '0;
        n_res.window_full = r_waiting;
        n_res.last        = 1'b1;
        if (i_ctrl.accept) begin
            rd_en = 1'b1;
            n_idx = '0;
            load  = 1'b1;
            unique case (i_in.command)
                gbn_pkg::CMD_SEND: begin
                    if (send_ok) begin
                        wr_en              = 1'b1;
                        n_next             = r_next + SB'(1);
                        n_waiting          = (outs + SB'(1)) >= win_ext;
                        n_res.accepted     = 1'b1;
                        n_res.pkt_valid    = 1'b1;
                        n_res.pkt_seq      = r_next;
                        n_res.pkt_payload  = i_in.payload;
                        n_res.timer_action = (outs == '0) ? gbn_pkg::TMR_START
                                                          : gbn_pkg::TMR_NONE;
                        n_res.window_full  = n_waiting;
                    end
                end
                gbn_pkg::CMD_ACK: begin
                    if (ack_good) begin
                        n_base             = ack_next;
                        n_base_slot        = wrap_slot((SLOT_W+1)'(r_base_slot)
                                                       + (SLOT_W+1)'(adv));
                        n_waiting          = outs_after_ack >= win_ext;
                        n_res.accepted     = 1'b1;
                        n_res.timer_action = (outs_after_ack == '0) ? gbn_pkg::TMR_STOP
                                                                    : gbn_pkg::TMR_RESTART;
                        n_res.window_full  = n_waiting;
                    end
                end
                gbn_pkg::CMD_TIMEOUT: begin
                    // a non-empty window starts a resend burst, results come later
                    load = (outs == '0);
                end
                default: begin
                    load = 1'b1;
                end
            endcase
        end else if (i_ctrl.retx_step) begin
            load               = 1'b1;
            n_res.pkt_valid    = 1'b1;
            n_res.pkt_seq      = r_base + SB'(r_idx);
            n_res.pkt_payload  = r_rd_data;
            n_res.timer_action = (r_idx == '0) ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE;
            n_res.last         = o_status.burst_last;
            n_idx              = idx_inc;
            rd_en              = 1'b1;
            rd_addr            = wrap_slot((SLOT_W+1)'(r_base_slot) + (SLOT_W+1)'(idx_inc));
        end
    end

    // window control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size  <= gbn_pkg::WIN_RESET;
            r_base      <= '0;
            r_next      <= '0;
            r_waiting   <= 1'b0;
            r_base_slot <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_win_size <= i_cfg_wdata;
            end
            r_base      <= n_base;
            r_next      <= n_next;
            r_waiting   <= n_waiting;
            r_base_slot <= n_base_slot;
            r_idx       <= n_idx;
        end
    end

    // packet store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= i_in.payload;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== src/go_back_n_sender.sv =====
// top level of the go-back-n sender window
//
//   channel   direction  handshake            payload
//   in        input      i_in_valid/o_in_stall   gbn_pkg::t_in_item
//   out       output     o_out_valid/i_out_stall gbn_pkg::t_out_item
//   cfg       input      i_cfg_we             i_cfg_wdata (window size)
//
// send, ack, refused and empty-timeout items each give one result; a timeout
// with n packets outstanding gives n results, one resent packet per result;
// one store read is issued per cycle on the single read port unless the output stalls.
// reset is synchronous; the store is not cleared, only written slots are read.
// a held result on the output stalls new items and the resend burst.
`default_nettype none

module go_back_n_sender #(
    parameter int BUFFER_DEPTH = gbn_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [gbn_pkg::WIN_BITS-1:0] i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire gbn_pkg::t_in_item            i_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output gbn_pkg::t_out_item                o_out
);

    gbn_pkg::t_dp_ctrl   ctrl;
    gbn_pkg::t_dp_status status;

    // command sequencing
    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    // window state, store and result register
    gbn_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== src/gbn_checker.sv =====
// port checks of the go-back-n sender and their binding
`default_nettype none

module gbn_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire gbn_pkg::t_out_item o_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("result dropped or changed while stalled");

    // items without a packet carry zero sequence and payload
    a_no_pkt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.pkt_valid) |-> (o_out.pkt_seq == '0 && o_out.pkt_payload == '0))
        else $error("empty result carries packet fields");

    // an accepted send starts the timer or leaves it alone
    a_send_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.accepted && o_out.pkt_valid)
            |-> (o_out.timer_action == gbn_pkg::TMR_NONE
                 || o_out.timer_action == gbn_pkg::TMR_START))
        else $error("bad timer action on send");

    // a resent packet after the burst head follows with the next sequence number
    a_burst_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out.pkt_valid && !o_out.accepted && !o_out.last)
            ##1 (o_out_valid && o_out.pkt_valid && !o_out.accepted)
            |-> (o_out.pkt_seq == $past(o_out.pkt_seq) + gbn_pkg::SEQ_BITS'(1)))
        else $error("resend burst out of order");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

// ===== tb/gbn_sender_checker.sv =====
// checker for the go-back-n sender: predicts every result item and compares
`default_nettype none

module gbn_sender_checker #(
    parameter int BUFFER_DEPTH = gbn_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [gbn_pkg::WIN_BITS-1:0] i_cfg_wdata,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_stall,
    input  wire gbn_pkg::t_in_item            i_in,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_stall,
    input  wire gbn_pkg::t_out_item           i_out,
    output int                                o_fail_count,
    output int                                o_pending,
    output logic [gbn_pkg::SEQ_BITS-1:0]      o_base,
    output logic [gbn_pkg::SEQ_BITS-1:0]      o_next
);
    timeunit 1ns;
    timeprecision 1ps;

    // mirrored sender state
    logic [gbn_pkg::WIN_BITS-1:0]     win_reg;
    logic [gbn_pkg::SEQ_BITS-1:0]     base_seq;
    logic [gbn_pkg::SEQ_BITS-1:0]     next_seq;
    logic                             full_flag;
    int                               base_slot;
    logic [gbn_pkg::PAYLOAD_BITS-1:0] sent_payloads [BUFFER_DEPTH];

    gbn_pkg::t_out_item awaited_results [$];
    int                 fails = 0;

    // window register saturated to what the store can hold
    function automatic int clamp_window(input logic [gbn_pkg::WIN_BITS-1:0] w);
        int cap;
        cap = (BUFFER_DEPTH < gbn_pkg::MAX_OUT) ? BUFFER_DEPTH : gbn_pkg::MAX_OUT;
        if (w < 1) return 1;
        if (int'(w) > cap) return cap;
        return int'(w);
    endfunction

    // queue one expected result, window_full taken from the state after the step
    task automatic await_result(input logic acc, input logic pv,
                                input logic [gbn_pkg::SEQ_BITS-1:0] seq,
                                input logic [gbn_pkg::PAYLOAD_BITS-1:0] pay,
                                input logic [1:0] tmr, input logic lst);
        gbn_pkg::t_out_item r;
        r.accepted     = acc;
        r.pkt_valid    = pv;
        r.pkt_seq      = seq;
        r.pkt_payload  = pay;
        r.timer_action = tmr;
        r.window_full  = full_flag;
        r.last         = lst;
        awaited_results.push_back(r);
    endtask

    // work out the results of one accepted command
    task automatic predict_command(input gbn_pkg::t_in_item cmd);
        int                           win;
        int                           outs;
        int                           ack_gap;
        int                           n;
        logic [gbn_pkg::SEQ_BITS-1:0] gap;
        logic [gbn_pkg::SEQ_BITS-1:0] seq;
        win = clamp_window(win_reg);
        gap = next_seq - base_seq;
        outs = int'(gap);
        case (cmd.command)
            gbn_pkg::CMD_SEND: begin
                if (full_flag || outs >= win) begin
                    await_result(1'b0, 1'b0, '0, '0, gbn_pkg::TMR_NONE, 1'b1);
                end else begin
                    sent_payloads[(base_slot + outs) % BUFFER_DEPTH] = cmd.payload;
                    seq = next_seq;
                    next_seq = next_seq + 1'b1;
                    if (outs + 1 >= win) full_flag = 1'b1;
                    await_result(1'b1, 1'b1, seq, cmd.payload,
                                 (outs == 0) ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE, 1'b1);
                end
            end
            gbn_pkg::CMD_ACK: begin
                gap = cmd.ack_num - base_seq;
                ack_gap = int'(gap);
                if (!cmd.ack_ok || ack_gap >= outs) begin
                    await_result(1'b0, 1'b0, '0, '0, gbn_pkg::TMR_NONE, 1'b1);
                end else begin
                    base_seq  = cmd.ack_num + 1'b1;
                    base_slot = (base_slot + ack_gap + 1) % BUFFER_DEPTH;
                    gap = next_seq - base_seq;
                    outs = int'(gap);
                    full_flag = (outs >= win);
                    await_result(1'b1, 1'b0, '0, '0,
                                 (outs == 0) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_RESTART,
                                 1'b1);
                end
            end
            gbn_pkg::CMD_TIMEOUT: begin
                if (outs == 0) begin
                    await_result(1'b0, 1'b0, '0, '0, gbn_pkg::TMR_NONE, 1'b1);
                end else begin
                    // resend burst, oldest packet first
                    n = (outs > gbn_pkg::MAX_OUT) ? gbn_pkg::MAX_OUT : outs;
                    for (int i = 0; i < n; i++) begin
                        seq = base_seq + gbn_pkg::SEQ_BITS'(i);
                        await_result(1'b0, 1'b1, seq,
                                     sent_payloads[(base_slot + i) % BUFFER_DEPTH],
                                     (i == 0) ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE,
                                     (i == n - 1));
                    end
                end
            end
            default: begin
                await_result(1'b0, 1'b0, '0, '0, gbn_pkg::TMR_NONE, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    // watch the channels at every edge
    always @(posedge i_clk) begin
        gbn_pkg::t_out_item want;
        if (!i_rst_n) begin
            win_reg   = gbn_pkg::WIN_RESET;
            base_seq  = '0;
            next_seq  = '0;
            full_flag = 1'b0;
            base_slot = 0;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) win_reg = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) predict_command(i_in);
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    fails++;
                    $display("%0t: result item with none expected, actual %p", $time, i_out);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("accepted", want.accepted, i_out.accepted);
                    check_field("pkt_valid", want.pkt_valid, i_out.pkt_valid);
                    check_field("pkt_seq", want.pkt_seq, i_out.pkt_seq);
                    check_field("pkt_payload", want.pkt_payload, i_out.pkt_payload);
                    check_field("timer_action", want.timer_action, i_out.timer_action);
                    check_field("window_full", want.window_full, i_out.window_full);
                    check_field("last", want.last, i_out.last);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
        o_base       <= base_seq;
        o_next       <= next_seq;
    end

endmodule

`default_nettype wire

// ===== tb/go_back_n_sender_test.sv =====
// top of the go-back-n sender testbench: clock, reset, stimulus and verdict
`default_nettype none

module go_back_n_sender_test;
    timeunit 1ns;
    timeprecision 1ps;

    // command code the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 34;
    localparam int HOLD_CYCLES     = 80;
    localparam int SETTLE_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [gbn_pkg::WIN_BITS-1:0] i_cfg_wdata = '0;
    logic                         i_in_valid  = 1'b0;
    gbn_pkg::t_in_item            i_in        = '0;
    logic                         i_out_stall = 1'b0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    gbn_pkg::t_out_item           o_out;

    int                           fail_count;
    int                           pending_results;
    logic [gbn_pkg::SEQ_BITS-1:0] seq_base;
    logic [gbn_pkg::SEQ_BITS-1:0] seq_next;

    bit quiet_mode  = 1'b0;
    bit hold_armed  = 1'b0;
    int idle_cycles = 0;

    always #5ns i_clk = ~i_clk;

    go_back_n_sender u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    gbn_sender_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_base       (seq_base),
        .o_next       (seq_next)
    );

    // receiver: random stalls, none in quiet mode, a long hold-off when armed
    initial begin : packet_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (quiet_mode) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 31);
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic gbn_pkg::t_in_item make_cmd(
        input logic [1:0]                     cmd,
        input logic [gbn_pkg::PAYLOAD_BITS-1:0] pay,
        input logic [gbn_pkg::SEQ_BITS-1:0]     ack,
        input logic                           ok
    );
        gbn_pkg::t_in_item it;
        it.command = cmd;
        it.payload = pay;
        it.ack_num = ack;
        it.ack_ok  = ok;
        return it;
    endfunction

    // mostly sends and acks near the window, some timeouts and noise
    function automatic gbn_pkg::t_in_item random_cmd(
        input logic [gbn_pkg::SEQ_BITS-1:0] base,
        input logic [gbn_pkg::SEQ_BITS-1:0] nxt
    );
        gbn_pkg::t_in_item            it;
        logic [gbn_pkg::SEQ_BITS-1:0] gap;
        int                           roll;
        int                           pick;
        gap = nxt - base;
        it.payload = $urandom();
        it.ack_num = $urandom();
        it.ack_ok  = ($urandom_range(99) < 85);
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        if (roll < 45) begin
            it.command = gbn_pkg::CMD_SEND;
        end else if (roll < 78) begin
            it.command = gbn_pkg::CMD_ACK;
            if (pick < 75) begin
                it.ack_num = base + gbn_pkg::SEQ_BITS'($urandom_range(int'(gap), 0));
            end else if (pick < 88) begin
                it.ack_num = base - 1'b1;
            end
        end else if (roll < 95) begin
            it.command = gbn_pkg::CMD_TIMEOUT;
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    // offer one item, after a random gap, and wait until it is taken
    task automatic push_cmd(input gbn_pkg::t_in_item it);
        while (!quiet_mode && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // stop offering and wait for every expected result, then let the block settle
    task automatic settle_outputs();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [gbn_pkg::WIN_BITS-1:0] w);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // window setting of each random phase, extremes included
    function automatic logic [gbn_pkg::WIN_BITS-1:0] phase_window(input int p);
        case (p)
            0:       return gbn_pkg::WIN_BITS'(8);
            1:       return gbn_pkg::WIN_BITS'(0);
            2:       return gbn_pkg::WIN_BITS'(15);
            3:       return gbn_pkg::WIN_BITS'(3);
            4:       return gbn_pkg::WIN_BITS'(6);
            default: return gbn_pkg::WIN_BITS'($urandom_range(15));
        endcase
    endfunction

    initial begin : stimulus
        int                n;
        gbn_pkg::t_in_item it;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty window: timeout and ack do nothing, unknown command ignored
        push_cmd(make_cmd(gbn_pkg::CMD_TIMEOUT, '0, '0, 1'b1));
        push_cmd(make_cmd(gbn_pkg::CMD_ACK, '0, '0, 1'b1));
        push_cmd(make_cmd(CMD_UNUSED, '1, '1, 1'b1));
        // fill the reset window of four, the first send starts the timer
        push_cmd(make_cmd(gbn_pkg::CMD_SEND, 32'h0000_0000, '0, 1'b0));
        push_cmd(make_cmd(gbn_pkg::CMD_SEND, 32'hffff_ffff, '1, 1'b1));
        push_cmd(make_cmd(gbn_pkg::CMD_SEND, 32'h5a5a_a5a5, '0, 1'b0));
        push_cmd(make_cmd(gbn_pkg::CMD_SEND, 32'h1234_5678, '0, 1'b0));
        // send while full is refused
        push_cmd(make_cmd(gbn_pkg::CMD_SEND, 32'h0f0f_0f0f, '0, 1'b0));
        // unverified ack, ack far out, ack equal to next
        push_cmd(make_cmd(gbn_pkg::CMD_ACK, '0, 16'd1, 1'b0));
        push_cmd(make_cmd(gbn_pkg::CMD_ACK, '0, 16'hffff, 1'b1));
        push_cmd(make_cmd(gbn_pkg::CMD_ACK, '0, 16'd4, 1'b1));
        // resend burst of four, then a partial ack restarts the timer
        push_cmd(make_cmd(gbn_pkg::CMD_TIMEOUT, '0, '0, 1'b0));
        push_cmd(make_cmd(gbn_pkg::CMD_ACK, '0, 16'd1, 1'b1));
        settle_outputs();

        // shrink the window under two outstanding packets
        write_window(gbn_pkg::WIN_BITS'(1));
        push_cmd(make_cmd(gbn_pkg::CMD_SEND, 32'h8000_0001, '0, 1'b0));
        push_cmd(make_cmd(gbn_pkg::CMD_TIMEOUT, '0, '0, 1'b0));
        push_cmd(make_cmd(gbn_pkg::CMD_ACK, '0, 16'd3, 1'b1));
        push_cmd(make_cmd(gbn_pkg::CMD_SEND, 32'h7fff_fffe, '0, 1'b0));
        push_cmd(make_cmd(gbn_pkg::CMD_ACK, '0, 16'd4, 1'b1));

        // random phases, one setting each
        for (int p = 0; p < PHASES; p++) begin
            settle_outputs();
            write_window(phase_window(p));
            quiet_mode = (p == 2);
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                if (p == 3 && n == 10) hold_armed = 1'b1;
                it = random_cmd(seq_base, seq_next);
                push_cmd(it);
                if (it.command != CMD_UNUSED) n++;
            end
        end
        quiet_mode = 1'b0;
        settle_outputs();

        if (fail_count == 0 && pending_results == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== go_back_n_sender.f =====
src/gbn_pkg.sv
src/gbn_ctrl.sv
src/gbn_dp.sv
src/go_back_n_sender.sv
src/gbn_checker.sv
tb/gbn_sender_checker.sv
tb/go_back_n_sender_test.sv
